/* rtl/ffpa_pkg.sv */
// Shared constants, types and command codes of the first-fit partition allocator.
`default_nettype none
package ffpa_pkg;

  localparam int NUM_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int ID_W       = $clog2(NUM_BLOCKS + 1);
  localparam int WIDE_W     = 8;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_REQ     = 2'd1;
  localparam logic [1:0] CMD_RESTART = 2'd2;

  localparam logic [4:0]  BLOCK_COUNT_RST = 5'd16;
  localparam logic [31:0] TOTAL_MAX       = 32'hFFFF_FFFF;

  typedef logic [SIZE_BITS-1:0] size_t;
  typedef logic [ID_W-1:0]      cell_id_t;

  // word travelling down the cell chain
  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
    logic [3:0] idx;
    size_t      size;
    logic       granted;
    logic [3:0] gidx;
    size_t      gsize;
    size_t      frag;
  } token_t;

endpackage
`default_nettype wire

/* rtl/ffpa_cell.sv */
// One partition cell: holds a block size and used bit, checks and claims a passing word.
`default_nettype none
module ffpa_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              advance_i,
  input  wire ffpa_pkg::cell_id_t cell_id_i,
  input  wire logic [4:0]        block_count_i,
  input  wire ffpa_pkg::token_t  tok_i,
  output ffpa_pkg::token_t       tok_o
);

  ffpa_pkg::size_t  size_q, size_d;
  logic             used_q, used_d;
  ffpa_pkg::token_t tok_q, tok_d;
  logic             match, eligible, fits;

  assign match    = ({4'd0, tok_i.idx} == ffpa_pkg::WIDE_W'(cell_id_i));
  assign eligible = (ffpa_pkg::WIDE_W'(block_count_i) > ffpa_pkg::WIDE_W'(cell_id_i));
  assign fits     = !used_q && (size_q >= tok_i.size);

  always_comb begin
    size_d = size_q;
    used_d = used_q;
    tok_d  = tok_i;
    if (tok_i.valid) begin
      unique case (tok_i.cmd)
        ffpa_pkg::CMD_LOAD: begin
          if (match) begin
            size_d = tok_i.size;
            used_d = 1'b0;
          end
        end
        ffpa_pkg::CMD_RESTART: begin
          used_d = 1'b0;
        end
        ffpa_pkg::CMD_REQ: begin
          if (!tok_i.granted && eligible && fits) begin
            used_d        = 1'b1;
            tok_d.granted = 1'b1;
            tok_d.gidx    = 4'(ffpa_pkg::WIDE_W'(cell_id_i));
            tok_d.gsize   = size_q;
            tok_d.frag    = size_q - tok_i.size;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      used_q <= 1'b0;
      tok_q  <= '0;
    end else if (advance_i) begin
      size_q <= size_d;
      used_q <= used_d;
      tok_q  <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

/* rtl/ffpa_total.sv */
// Chain exit: saturating fragment total and the result output register.
`default_nettype none
module ffpa_total (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             advance_i,
  input  wire ffpa_pkg::token_t tok_i,
  output logic                  out_valid_o,
  output logic                  allocated_o,
  output logic [3:0]            granted_block_o,
  output logic [15:0]           granted_block_size_o,
  output logic [15:0]           fragment_o,
  output logic [31:0]           total_fragment_o
);

  logic [31:0] total_q, total_d;
  logic [32:0] sum;
  logic        valid_q;
  logic        alloc_q;
  logic [3:0]  gidx_q;
  logic [15:0] gsize_q, frag_q;

  assign sum = {1'b0, total_q} + 33'(32'(tok_i.frag));

  always_comb begin
    total_d = total_q;
    if (tok_i.valid) begin
      if (tok_i.cmd == ffpa_pkg::CMD_RESTART) begin
        total_d = '0;
      end else if (tok_i.granted) begin
        total_d = sum[32] ? ffpa_pkg::TOTAL_MAX : sum[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      valid_q <= 1'b0;
    end else if (advance_i) begin
      total_q <= total_d;
      valid_q <= tok_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      alloc_q <= tok_i.granted;
      gidx_q  <= tok_i.gidx;
      gsize_q <= 16'(32'(tok_i.gsize));
      frag_q  <= 16'(32'(tok_i.frag));
    end
  end

  assign out_valid_o          = valid_q;
  assign allocated_o          = alloc_q;
  assign granted_block_o      = gidx_q;
  assign granted_block_size_o = gsize_q;
  assign fragment_o           = frag_q;
  assign total_fragment_o     = total_q;

endmodule
`default_nettype wire

/* rtl/first_fit_partition_allocator_unit.sv */
// Top level of the first-fit fixed-partition allocator: a chain of partition cells.
//
//  channel  dir  handshake                  payload
//  s_axis   in   s_axis_tvalid/tready       tuser: cmd; tdata: block_index, size_value
//  m_axis   out  m_axis_tvalid/tready       tuser: allocated; tdata: block, size, frag, total
//  cfg      in   cfg_we_i                   cfg_wdata_i: block_count
//
// Every word walks through the NUM_BLOCKS cells in order, then the total register;
// one word per cycle sustained while m_axis_tready is high.
// Reset clears all sizes, used bits and the total; block_count resets to 16.
// A result held in the output register with tready low stalls the whole chain and input.
`default_nettype none
module first_fit_partition_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,  // [3:0] block_index, [19:4] size_value, zero pad
  input  wire logic [1:0]  s_axis_tuser,  // [1:0] cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] granted_block, [19:4] granted_block_size, [35:20] fragment,
  // [67:36] total_fragment, zero pad
  output logic [71:0]      m_axis_tdata,
  output logic             m_axis_tuser,  // [0] allocated
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i
);

  logic             advance;
  logic [4:0]       block_count_q;
  ffpa_pkg::token_t in_tok;
  ffpa_pkg::token_t chain [ffpa_pkg::NUM_BLOCKS+1];
  logic [3:0]       granted_block;
  logic [15:0]      granted_block_size, fragment;
  logic [31:0]      total_fragment;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= ffpa_pkg::BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      block_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    in_tok       = '0;
    in_tok.valid = s_axis_tvalid;
    in_tok.cmd   = s_axis_tuser;
    in_tok.idx   = s_axis_tdata[3:0];
    in_tok.size  = ffpa_pkg::size_t'(32'(s_axis_tdata[19:4]));
  end

  assign chain[0] = in_tok;

  for (genvar g = 0; g < ffpa_pkg::NUM_BLOCKS; g++) begin : g_cell
    ffpa_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .advance_i     (advance),
      .cell_id_i     (ffpa_pkg::cell_id_t'(g)),
      .block_count_i (block_count_q),
      .tok_i         (chain[g]),
      .tok_o         (chain[g+1])
    );
  end

  ffpa_total u_total (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .advance_i            (advance),
    .tok_i                (chain[ffpa_pkg::NUM_BLOCKS]),
    .out_valid_o          (m_axis_tvalid),
    .allocated_o          (m_axis_tuser),
    .granted_block_o      (granted_block),
    .granted_block_size_o (granted_block_size),
    .fragment_o           (fragment),
    .total_fragment_o     (total_fragment)
  );

  assign m_axis_tdata = {4'd0, total_fragment, fragment, granted_block_size, granted_block};

endmodule
`default_nettype wire
